// ===== rtl/nbc_pkg.sv =====
`timescale 1ns / 1ps

package nbc_pkg;

  localparam int ROUNDS = 16;

  typedef logic [31:0] word_t;
  typedef word_t [3:0] block_t;
  typedef logic [7:0] rc_t;

  typedef struct packed {
    logic valid;
    logic mode;
  } ctrl_t;

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  // Round constants 0..ROUNDS; the last ends encryption and begins decryption.
  localparam rc_t RCON [0:ROUNDS] = '{
    8'h80, 8'h1B, 8'h36, 8'h6C, 8'hD8, 8'hAB, 8'h4D, 8'h9A,
    8'h2F, 8'h5E, 8'hBC, 8'h63, 8'hC6, 8'h97, 8'h35, 8'h6A, 8'hD4
  };

  function automatic word_t rotl(input word_t x, input int n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

  function automatic block_t theta(input block_t a, input block_t k);
    block_t b;
    word_t  t;
    b = a;
    t = b[0] ^ b[2];
    t = t ^ rotl(t, 8) ^ rotl(t, 24);
    b[1] = b[1] ^ t;
    b[3] = b[3] ^ t;
    b[0] = b[0] ^ k[0];
    b[1] = b[1] ^ k[1];
    b[2] = b[2] ^ k[2];
    b[3] = b[3] ^ k[3];
    t = b[1] ^ b[3];
    t = t ^ rotl(t, 8) ^ rotl(t, 24);
    b[0] = b[0] ^ t;
    b[2] = b[2] ^ t;
    return b;
  endfunction

  function automatic block_t pi_gamma_pi(input block_t a);
    block_t b;
    word_t  t;
    b = a;
    b[1] = rotl(b[1], 1);
    b[2] = rotl(b[2], 5);
    b[3] = rotl(b[3], 2);
    b[1] = b[1] ^ (~b[3] & ~b[2]);
    b[0] = b[0] ^ (b[2] & b[1]);
    t = b[3];
    b[3] = b[0];
    b[0] = t;
    b[2] = b[2] ^ b[0] ^ b[1] ^ b[3];
    b[1] = b[1] ^ (~b[3] & ~b[2]);
    b[0] = b[0] ^ (b[2] & b[1]);
    b[1] = rotl(b[1], 31);
    b[2] = rotl(b[2], 27);
    b[3] = rotl(b[3], 30);
    return b;
  endfunction

endpackage

// ===== rtl/nbc_round_cell.sv =====
`timescale 1ns / 1ps

module nbc_round_cell import nbc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  ctrl_t  ctrl_in,
  input  block_t data_in,
  input  block_t enc_key,
  input  block_t dec_key,
  input  rc_t    rc_enc,
  input  rc_t    rc_dec,
  output ctrl_t  ctrl_out,
  output block_t data_out
);

  block_t data_next;
  block_t pre;

  // Encryption adds the constant before theta, decryption after it.
  always_comb begin
    pre = data_in;
    if (ctrl_in.mode == MODE_DEC) begin
      pre = theta(data_in, dec_key);
      pre[0] = pre[0] ^ {24'd0, rc_dec};
    end else begin
      pre[0] = pre[0] ^ {24'd0, rc_enc};
      pre = theta(pre, enc_key);
    end
    data_next = pi_gamma_pi(pre);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out <= '0;
    end else begin
      ctrl_out <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    data_out <= data_next;
  end

endmodule

// ===== rtl/nbc_final_cell.sv =====
`timescale 1ns / 1ps

module nbc_final_cell import nbc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  ctrl_t  ctrl_in,
  input  block_t data_in,
  input  block_t enc_key,
  input  block_t dec_key,
  output logic   done,
  output block_t data_out
);

  block_t data_next;

  always_comb begin
    data_next = data_in;
    if (ctrl_in.mode == MODE_DEC) begin
      data_next = theta(data_in, dec_key);
      data_next[0] = data_next[0] ^ {24'd0, RCON[0]};
    end else begin
      data_next[0] = data_next[0] ^ {24'd0, RCON[ROUNDS]};
      data_next = theta(data_next, enc_key);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    data_out <= data_next;
  end

endmodule

// ===== rtl/noekeon_block_cipher.sv =====
`timescale 1ns / 1ps

// Noekeon 128-bit cipher in direct-key mode, one round cell per round followed by
// an output cell. A new block is accepted on every cycle where start is high; busy is always low.
// Each result appears on done and out_w0..out_w3 after passing through the 16 round cells
// and then the output cell. Results leave in the order their blocks entered, one per cycle.
// The receiver cannot stall, so it must take every done cycle as it comes. The working
// keys (indexes 0..3 encryption, 4..7 decryption) may be written only when no block is in flight.

module noekeon_block_cipher import nbc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [31:0] in_w0,
  input  logic [31:0] in_w1,
  input  logic [31:0] in_w2,
  input  logic [31:0] in_w3,
  output logic        done,
  output logic [31:0] out_w0,
  output logic [31:0] out_w1,
  output logic [31:0] out_w2,
  output logic [31:0] out_w3,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [2:0] REG_ENC0 = 3'd0;
  localparam logic [2:0] REG_ENC1 = 3'd1;
  localparam logic [2:0] REG_ENC2 = 3'd2;
  localparam logic [2:0] REG_ENC3 = 3'd3;
  localparam logic [2:0] REG_DEC0 = 3'd4;
  localparam logic [2:0] REG_DEC1 = 3'd5;
  localparam logic [2:0] REG_DEC2 = 3'd6;
  localparam logic [2:0] REG_DEC3 = 3'd7;

  block_t enc_key;
  block_t dec_key;
  ctrl_t  stage_ctrl [0:ROUNDS];
  block_t stage_data [0:ROUNDS];
  block_t result;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      enc_key <= '0;
      dec_key <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENC0: enc_key[0] <= cfg_data;
        REG_ENC1: enc_key[1] <= cfg_data;
        REG_ENC2: enc_key[2] <= cfg_data;
        REG_ENC3: enc_key[3] <= cfg_data;
        REG_DEC0: dec_key[0] <= cfg_data;
        REG_DEC1: dec_key[1] <= cfg_data;
        REG_DEC2: dec_key[2] <= cfg_data;
        REG_DEC3: dec_key[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign stage_ctrl[0].valid = start;
  assign stage_ctrl[0].mode  = mode;
  assign stage_data[0]       = {in_w3, in_w2, in_w1, in_w0};

  for (genvar i = 0; i < ROUNDS; i++) begin : g_round
    nbc_round_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl_in  (stage_ctrl[i]),
      .data_in  (stage_data[i]),
      .enc_key  (enc_key),
      .dec_key  (dec_key),
      .rc_enc   (RCON[i]),
      .rc_dec   (RCON[ROUNDS - i]),
      .ctrl_out (stage_ctrl[i + 1]),
      .data_out (stage_data[i + 1])
    );
  end

  nbc_final_cell u_final (
    .clk      (clk),
    .rst      (rst),
    .ctrl_in  (stage_ctrl[ROUNDS]),
    .data_in  (stage_data[ROUNDS]),
    .enc_key  (enc_key),
    .dec_key  (dec_key),
    .done     (done),
    .data_out (result)
  );

  assign out_w0 = result[0];
  assign out_w1 = result[1];
  assign out_w2 = result[2];
  assign out_w3 = result[3];

endmodule

// ===== sim/noekeon_block_checker.sv =====
`timescale 1ns / 1ps

module noekeon_block_checker import nbc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        mode,
  input  logic [31:0] in_w0,
  input  logic [31:0] in_w1,
  input  logic [31:0] in_w2,
  input  logic [31:0] in_w3,
  input  logic        done,
  input  logic [31:0] out_w0,
  input  logic [31:0] out_w1,
  input  logic [31:0] out_w2,
  input  logic [31:0] out_w3,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          outstanding,
  output int          fail_count
);

  localparam logic [7:0] ROUND_CONST [0:16] = '{
    8'h80, 8'h1B, 8'h36, 8'h6C, 8'hD8, 8'hAB, 8'h4D, 8'h9A,
    8'h2F, 8'h5E, 8'hBC, 8'h63, 8'hC6, 8'h97, 8'h35, 8'h6A, 8'hD4
  };

  block_t enc_key;
  block_t dec_key;
  block_t expected_blocks [$];

  function automatic word_t rot_left(input word_t x, input int unsigned n);
    int unsigned s;
    s = n % 32;
    if (s == 0) return x;
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic word_t spread(input word_t t);
    return t ^ rot_left(t, 8) ^ rot_left(t, 24);
  endfunction

  // Linear layer: the key is added between the two diffusion halves.
  function automatic block_t key_mix(input block_t a, input block_t k);
    block_t r;
    word_t  t;
    r = a;
    t = spread(r[0] ^ r[2]);
    r[1] ^= t;
    r[3] ^= t;
    r = r ^ k;
    t = spread(r[1] ^ r[3]);
    r[0] ^= t;
    r[2] ^= t;
    return r;
  endfunction

  function automatic block_t sbox_layer(input block_t a);
    block_t r;
    word_t  t;
    r = a;
    r[1] = rot_left(r[1], 1);
    r[2] = rot_left(r[2], 5);
    r[3] = rot_left(r[3], 2);
    r[1] ^= ~r[3] & ~r[2];
    r[0] ^= r[2] & r[1];
    t = r[3];
    r[3] = r[0];
    r[0] = t;
    r[2] ^= r[0] ^ r[1] ^ r[3];
    r[1] ^= ~r[3] & ~r[2];
    r[0] ^= r[2] & r[1];
    r[1] = rot_left(r[1], 31);
    r[2] = rot_left(r[2], 27);
    r[3] = rot_left(r[3], 30);
    return r;
  endfunction

  function automatic block_t noekeon_transform(input logic m, input block_t a,
                                               input block_t ek, input block_t dk);
    block_t r;
    r = a;
    if (m == MODE_ENC) begin
      for (int i = 0; i < ROUNDS; i++) begin
        r[0] ^= 32'(ROUND_CONST[i]);
        r = sbox_layer(key_mix(r, ek));
      end
      r[0] ^= 32'(ROUND_CONST[ROUNDS]);
      r = key_mix(r, ek);
    end else begin
      // Decryption walks the constants backward and adds each after the linear layer.
      for (int i = 0; i < ROUNDS; i++) begin
        r = key_mix(r, dk);
        r[0] ^= 32'(ROUND_CONST[ROUNDS - i]);
        r = sbox_layer(r);
      end
      r = key_mix(r, dk);
      r[0] ^= 32'(ROUND_CONST[0]);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    block_t got;
    block_t want;
    logic   took;
    took = 1'b0;
    if (rst) begin
      enc_key = '0;
      dec_key = '0;
      expected_blocks.delete();
      fail_count = 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index[2]) dec_key[cfg_index[1:0]] = cfg_data;
        else enc_key[cfg_index[1:0]] = cfg_data;
      end
      if (start && !busy) begin
        expected_blocks.push_back(noekeon_transform(mode, {in_w3, in_w2, in_w1, in_w0},
                                                    enc_key, dec_key));
      end
      if (done) begin
        got = {out_w3, out_w2, out_w1, out_w0};
        if (expected_blocks.size() == 0) begin
          $error("result transaction with no block in flight: %032h", got);
          fail_count++;
        end else begin
          want = expected_blocks.pop_front();
          took = 1'b1;
          for (int i = 0; i < 4; i++) begin
            if (got[i] !== want[i]) begin
              $error("out_w%0d mismatch: expected %08h, actual %08h", i, want[i], got[i]);
              fail_count++;
            end
          end
        end
      end
      outstanding <= outstanding + int'(start && !busy) - int'(took);
    end
  end

endmodule

// ===== sim/tb_noekeon_block_cipher.sv =====
`timescale 1ns / 1ps

module tb_noekeon_block_cipher;
  import nbc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 24;
  localparam int BLOCKS_PER_KEY = 150;
  localparam int KEY_SETTINGS   = 6;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        mode = MODE_ENC;
  logic [31:0] in_w0 = '0;
  logic [31:0] in_w1 = '0;
  logic [31:0] in_w2 = '0;
  logic [31:0] in_w3 = '0;
  logic        done;
  logic [31:0] out_w0;
  logic [31:0] out_w1;
  logic [31:0] out_w2;
  logic [31:0] out_w3;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          outstanding;
  int          fail_count;
  int          quiet_cycles = 0;

  always #4 clk = ~clk;

  noekeon_block_cipher dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .in_w0(in_w0), .in_w1(in_w1), .in_w2(in_w2), .in_w3(in_w3),
    .done(done), .out_w0(out_w0), .out_w1(out_w1), .out_w2(out_w2), .out_w3(out_w3),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  noekeon_block_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .in_w0(in_w0), .in_w1(in_w1), .in_w2(in_w2), .in_w3(in_w3),
    .done(done), .out_w0(out_w0), .out_w1(out_w1), .out_w2(out_w2), .out_w3(out_w3),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .outstanding(outstanding), .fail_count(fail_count)
  );

  // Any transaction or key write restarts the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic word_t pick_word();
    case ($urandom_range(0, 15))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h1 << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_block(input logic m, input block_t b, input int gap);
    start <= 1'b1;
    mode  <= m;
    in_w0 <= b[0];
    in_w1 <= b[1];
    in_w2 <= b[2];
    in_w3 <= b[3];
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Keys change only with the pipeline empty.
  task automatic load_keys(input block_t ek, input block_t dk);
    wait_drained();
    cfg_we <= 1'b1;
    for (int i = 0; i < 8; i++) begin
      cfg_index <= 3'(i);
      cfg_data  <= (i < 4) ? ek[i % 4] : dk[i % 4];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_both_modes(input block_t b);
    send_block(MODE_ENC, b, 0);
    send_block(MODE_DEC, b, 1);
  endtask

  initial begin
    block_t ek;
    block_t dk;
    logic   gappy;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset keys are zero.
    send_both_modes('0);
    send_both_modes('1);
    send_block(MODE_ENC, {4{32'hAAAA_AAAA}}, 0);
    send_block(MODE_DEC, {4{32'h5555_5555}}, 0);
    send_block(MODE_ENC, {32'h0000_0001, 32'h0, 32'h0, 32'h8000_0000}, 2);
    send_block(MODE_DEC, {32'h8000_0000, 32'h0, 32'h0, 32'h0000_0001}, 0);

    load_keys('1, '1);
    send_both_modes('0);
    send_both_modes('1);

    load_keys({4{32'hA5A5_5A5A}}, {4{32'h5A5A_A5A5}});
    send_both_modes({32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210});

    for (int s = 0; s < KEY_SETTINGS; s++) begin
      for (int i = 0; i < 4; i++) begin
        ek[i] = pick_word();
        dk[i] = pick_word();
      end
      if (s == 1) begin
        ek = '0;
        dk = '1;
      end
      load_keys(ek, dk);
      // Setting 2 always runs back to back so the pipeline stays full; others may at random.
      gappy = (s != 2) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < BLOCKS_PER_KEY; n++) begin
        send_block($urandom_range(0, 1) ? MODE_DEC : MODE_ENC,
                   {pick_word(), pick_word(), pick_word(), pick_word()},
                   gappy ? pick_gap() : 0);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
